// ----- rtl/bwrd_pkg.sv -----
// shared types and constants for the band width regime detector
// no dependencies
package bwrd_pkg;
  localparam int unsigned MaxWindowDef = 64;
  localparam int unsigned PriceBitsDef = 24;
  localparam int unsigned RegBits      = 2;
  localparam logic [6:0]  WinLenReset  = 7'd20;
  localparam logic [15:0] ConfReset    = 16'd3;
  localparam logic [31:0] ThrReset     = 32'd262144;

  typedef enum logic [1:0] {
    REG_WINLEN = 2'd0,
    REG_CONFIRM = 2'd1,
    REG_THRESH = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RG_WAIT = 2'd0,
    RG_CONS = 2'd1,
    RG_TREND = 2'd2
  } regime_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_UPD, ST_MUL1, ST_MUL2, ST_VDIV, ST_SQRT,
    ST_MDIV, ST_BAND, ST_WDIV, ST_DEC, ST_OUT
  } state_e;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage

// ----- rtl/bwrd_ram.sv -----
// generic single port ram with registered read
// no dependencies
module bwrd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

// ----- rtl/bwrd_div.sv -----
// shared restoring divider, one quotient bit per cycle, 64 bit
// depends on bwrd_pkg
module bwrd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bwrd_pkg::div_req_t req_i,
  output bwrd_pkg::div_rsp_t rsp_o
);
  import bwrd_pkg::*;
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [64:0] trial;
  logic [63:0] shr;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q; busy_d = busy_q;
    shr   = {rem_q[62:0], quo_q[63]};
    trial = {1'b0, shr} - {1'b0, den_q};
    rsp_o.done = 1'b0;
    rsp_o.quo  = quo_q;
    if (req_i.start) begin
      rem_d = '0; quo_d = req_i.num; den_d = req_i.den; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q[63] == 1'b0 && !trial[64]) begin
        rem_d = trial[63:0]; quo_d = {quo_q[62:0], 1'b1};
      end else if (rem_q[63]) begin
        rem_d = shr - den_q; quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shr; quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end else begin
      rsp_o.done = 1'b0;
    end
    if (busy_q && cnt_q == 7'd1) rsp_o.done = 1'b1;
    if (busy_q && cnt_q == 7'd1) rsp_o.quo = quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end
endmodule

// ----- rtl/band_width_regime_detector.sv -----
// band width regime detector top level: sequencer, window ram, shared divider
// depends on bwrd_pkg, bwrd_ram, bwrd_div
//
// channel | dir | fields (low bit first)
// s_axis  | in  | tdata: close_price[23:0]
// m_axis  | out | tdata: regime, band_middle, band_upper, band_lower, width_percent, window_full
// cfg     | in  | we, index, 32 bit data
//
// a price on a full window goes from accept to the next ready through up to three passes of
// the 64 step divider and a 32 step square root
// a price still filling the window skips divider and root; a zero price goes straight to output
// the result sits in an output register; s_axis is not ready until it is taken, so an
// m_axis stall holds off the next price
// reset clears all control and running state; the window ram needs no clearing
module band_width_regime_detector #(
  parameter int unsigned MaxWindow = bwrd_pkg::MaxWindowDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // close_price
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [111:0] m_axis_tdata,  // regime, middle, upper, lower, width, full
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import bwrd_pkg::*;
  localparam int unsigned AW = $clog2(MaxWindow);

  state_e st_q, st_d;
  logic [6:0]  wlen_q; logic [15:0] conf_q; logic [31:0] thr_q;
  logic [AW-1:0] wp_q, wp_d;
  logic [6:0]  fill_q, fill_d;
  logic [30:0] s1_q, s1_d;
  logic [54:0] s2_q, s2_d;
  logic [1:0]  cur_q, cur_d, pend_q, pend_d;
  logic [15:0] ccnt_q, ccnt_d;
  logic [23:0] mid_q, mid_d;
  logic [24:0] up_q, up_d, lo_q, lo_d;
  logic [31:0] wid_q, wid_d;
  logic [23:0] price_q, price_d;
  logic [63:0] acc_q, acc_d;   // multiplier / work register
  logic [63:0] var_q, var_d;
  logic [31:0] root_q, root_d;
  logic [5:0]  it_q, it_d;
  logic        ovalid_q, ovalid_d;
  logic [111:0] odata_q, odata_d;
  logic        we;
  logic [23:0] rdata;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [63:0] mulop;
  logic [31:0] ma, mb;
  logic [1:0]  reading;
  logic        full;
  logic [6:0]  cfgw;

  bwrd_ram #(.Width(24), .Depth(MaxWindow)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(wp_q), .wdata_i(price_q), .rdata_o(rdata));
  bwrd_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign mulop = {32'd0, ma} * {32'd0, mb};
  assign full  = (fill_q == wlen_q);
  assign s_axis_tready = (st_q == ST_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign cfgw = (cfg_data_i[6:0] < 7'd2) ? 7'd2 :
                ({25'd0, cfg_data_i[6:0]} > MaxWindow) ? MaxWindow[6:0] : cfg_data_i[6:0];

  always_comb begin
    st_d = st_q; wp_d = wp_q; fill_d = fill_q; s1_d = s1_q; s2_d = s2_q;
    cur_d = cur_q; pend_d = pend_q; ccnt_d = ccnt_q;
    mid_d = mid_q; up_d = up_q; lo_d = lo_q; wid_d = wid_q;
    price_d = price_q; acc_d = acc_q; var_d = var_q; root_d = root_q; it_d = it_q;
    ovalid_d = ovalid_q; odata_d = odata_q;
    we = 1'b0; dreq = '0; ma = '0; mb = '0; reading = RG_CONS;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    case (st_q)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        price_d = s_axis_tdata;
        st_d = (s_axis_tdata == '0) ? ST_OUT : ST_READ;
      end
      ST_READ: st_d = ST_UPD;   // ram read of the oldest entry
      ST_UPD: begin
        ma = {8'd0, rdata}; mb = {8'd0, rdata};
        acc_d = mulop;
        st_d = ST_MUL1;
      end
      ST_MUL1: begin
        ma = {8'd0, price_q}; mb = {8'd0, price_q};
        we = 1'b1;
        if (fill_q >= wlen_q) begin
          s1_d = s1_q - {7'd0, rdata} + {7'd0, price_q};
          s2_d = s2_q - acc_q[54:0] + mulop[54:0];
        end else begin
          s1_d = s1_q + {7'd0, price_q};
          s2_d = s2_q + mulop[54:0];
          fill_d = fill_q + 7'd1;
        end
        wp_d = ({{(32-AW){1'b0}}, wp_q} + 32'd1 >= {25'd0, wlen_q}) ? '0 : wp_q + 1'b1;
        st_d = ST_MUL2;
      end
      ST_MUL2: begin
        if (fill_q < wlen_q) begin
          cur_d = RG_WAIT; st_d = ST_OUT;
        end else begin
          // n*S2 - S1^2 in two steps: S1^2 first, then the difference
          if (it_q == 6'd0) begin
            ma = {1'b0, s1_q}; mb = {1'b0, s1_q}; acc_d = mulop; it_d = 6'd1;
          end else begin
            var_d = ({9'd0, s2_q} * {57'd0, wlen_q}) - acc_q;
            it_d = '0;
            dreq.start = 1'b1; dreq.num = ({9'd0, s2_q} * {57'd0, wlen_q}) - acc_q;
            dreq.den = {50'd0, 14'(wlen_q) * 14'(wlen_q)};
            st_d = ST_VDIV;
          end
        end
      end
      ST_VDIV: if (drsp.done) begin
        var_d = drsp.quo; root_d = '0; it_d = 6'd31; st_d = ST_SQRT;
      end
      ST_SQRT: begin
        // bit by bit square root, one bit per cycle
        root_d = root_q | (32'd1 << it_q);
        ma = root_q | (32'd1 << it_q); mb = root_q | (32'd1 << it_q);
        if (mulop > var_q) root_d = root_q;
        it_d = it_q - 6'd1;
        if (it_q == 6'd0) begin
          it_d = '0;
          dreq.start = 1'b1; dreq.num = {33'd0, s1_q}; dreq.den = {57'd0, wlen_q};
          st_d = ST_MDIV;
        end
      end
      ST_MDIV: if (drsp.done) begin
        acc_d = drsp.quo; st_d = ST_BAND;
      end
      ST_BAND: begin
        mid_d = acc_q[23:0];
        up_d = acc_q[24:0] + {root_q[23:0], 1'b0};
        lo_d = acc_q[24:0] - {root_q[23:0], 1'b0};
        ma = root_q; mb = 32'd400;
        if (acc_q == '0) begin
          wid_d = '0; st_d = ST_DEC;
        end else begin
          dreq.start = 1'b1; dreq.num = {mulop[47:0], 16'd0}; dreq.den = acc_q;
          st_d = ST_WDIV;
        end
      end
      ST_WDIV: if (drsp.done) begin
        wid_d = (drsp.quo[63:32] != '0) ? 32'hFFFF_FFFF : drsp.quo[31:0];
        st_d = ST_DEC;
      end
      ST_DEC: begin
        reading = (wid_q <= thr_q) ? RG_CONS : RG_TREND;
        if (reading != cur_q) begin
          if (reading == pend_q) begin
            if (ccnt_q != 16'hFFFF) ccnt_d = ccnt_q + 16'd1;
            if (((ccnt_q != 16'hFFFF) ? ccnt_q + 16'd1 : ccnt_q) >= conf_q) begin
              cur_d = reading; ccnt_d = '0; pend_d = RG_WAIT;
            end
          end else begin
            pend_d = reading; ccnt_d = 16'd1;
          end
        end else begin
          pend_d = RG_WAIT; ccnt_d = '0;
        end
        st_d = ST_OUT;
      end
      ST_OUT: begin
        odata_d = {3'd0, full, wid_q, lo_q, up_q, mid_q, cur_q};
        ovalid_d = 1'b1; st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
    if (cfg_we_i && cfg_index_i == REG_WINLEN) begin
      wp_d = '0; fill_d = '0; s1_d = '0; s2_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; wlen_q <= WinLenReset; conf_q <= ConfReset; thr_q <= ThrReset;
      wp_q <= '0; fill_q <= '0; s1_q <= '0; s2_q <= '0;
      cur_q <= RG_WAIT; pend_q <= RG_WAIT; ccnt_q <= '0;
      mid_q <= '0; up_q <= '0; lo_q <= '0; wid_q <= '0;
      ovalid_q <= 1'b0; it_q <= '0;
    end else begin
      st_q <= st_d; wp_q <= wp_d; fill_q <= fill_d; s1_q <= s1_d; s2_q <= s2_d;
      cur_q <= cur_d; pend_q <= pend_d; ccnt_q <= ccnt_d;
      mid_q <= mid_d; up_q <= up_d; lo_q <= lo_d; wid_q <= wid_d;
      ovalid_q <= ovalid_d; it_q <= it_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WINLEN:  wlen_q <= cfgw;
          REG_CONFIRM: conf_q <= cfg_data_i[15:0];
          REG_THRESH:  thr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
  always_ff @(posedge clk_i) begin
    price_q <= price_d; acc_q <= acc_d; var_q <= var_d; root_q <= root_d;
    odata_q <= odata_d;
  end
endmodule
